// File: src/kvc_pkg.sv
// shared types and constants for the lru key-value cache
`default_nettype none

package kvc_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int CAP_W   = 5;
   localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int DATA_W  = 32;

   localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
   localparam logic [DATA_W-1:0] MISS_VALUE = '1;

   typedef enum logic {
      CMD_SET = 1'b0,
      CMD_GET = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type           command;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] value;
   } rsp_type;

   typedef struct packed {
      logic [ENTRIES-1:0] valid;
      logic [CNT_W-1:0]   count;
   } status_type;

endpackage

`default_nettype wire

// File: src/kvc_store.sv
// entry storage, parallel key match and recency ranking with replacement
`default_nettype none

module kvc_store import kvc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  req_type          req,
   input  logic [CMP_W-1:0] cap_eff,
   output rsp_type          lookup,
   output status_type       status
);

   logic [DATA_W-1:0] key_ff   [ENTRIES];
   logic [DATA_W-1:0] value_ff [ENTRIES];
   logic [IDX_W-1:0]  rank_ff  [ENTRIES];
   logic [IDX_W-1:0]  rank_in  [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic [ENTRIES-1:0] match;
   logic               hit;
   logic [IDX_W-1:0]   hit_idx, vic_idx, free_idx, slot, old_rank, last_rank;
   logic               is_set, is_full, evict, insert, update;

   assign last_rank = IDX_W'(count_ff - CNT_W'(1));

   // key match, victim and free slot
   always_comb begin
      hit_idx  = '0;
      vic_idx  = '0;
      free_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == req.key);
         if (match[i]) hit_idx = hit_idx | IDX_W'(i);
         if (valid_ff[i] && (rank_ff[i] == last_rank)) vic_idx = vic_idx | IDX_W'(i);
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) free_idx = IDX_W'(i);
      end
      hit = |match;
   end

   assign is_set  = (req.command == CMD_SET);
   assign is_full = (CMP_W'(count_ff) >= cap_eff);
   assign evict   = is_set && !hit && is_full;
   assign insert  = is_set && !hit && !is_full;
   assign update  = fire && (is_set || hit);
   assign slot     = hit ? hit_idx : (evict ? vic_idx : free_idx);
   assign old_rank = hit ? rank_ff[hit_idx] : last_rank;

   // recency update: entries more recent than the touched one age by one
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      for (int i = 0; i < ENTRIES; i++) rank_in[i] = rank_ff[i];
      if (update) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (IDX_W'(i) == slot) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (insert || (rank_ff[i] < old_rank))) begin
               rank_in[i] = rank_ff[i] + IDX_W'(1);
            end
         end
         if (insert) begin
            valid_in[slot] = 1'b1;
            count_in       = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) rank_ff[i] <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int i = 0; i < ENTRIES; i++) rank_ff[i] <= rank_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (update && is_set) begin
         value_ff[slot] <= req.value;
         if (!hit) key_ff[slot] <= req.key;
      end
   end

   assign lookup.hit   = hit;
   assign lookup.value = hit ? value_ff[hit_idx] : MISS_VALUE;
   assign status.valid = valid_ff;
   assign status.count = count_ff;

endmodule

`default_nettype wire

// File: src/lru_key_value_cache.sv
// Fully associative 16-entry key-value cache with least-recently-used replacement.
// Takes one request per cycle unless a get stalls. A request is held in an input
// register, where all keys are matched in parallel; the recency ranks are updated
// in a single pass as the request leaves it. A get's result is loaded into the
// output register as the get leaves. A set in the input register never stalls and
// gives no result; a get waits in the input register only while the previous
// result has not been taken, and any request behind it waits too. The user must
// write capacity through the csr port only while the cache is idle; the block
// does not enforce this. Zero is treated as one and values above 16 as 16.
`default_nettype none

module lru_key_value_cache import kvc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_command,
   input  logic signed [DATA_W-1:0] req_key,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_hit,
   output logic signed [DATA_W-1:0] rsp_value_res,
   input  logic                     csr_write_enable,
   input  logic [CAP_W-1:0]         csr_write_data
);

   logic             in_valid_ff, in_valid_in;
   req_type          req_ff, req_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [CMP_W-1:0] cap_eff;
   logic             fire, req_xfer, rsp_load;
   rsp_type          lookup;
   status_type       status;

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end else begin
         cap_eff = CMP_W'(cap_ff);
      end
   end

   assign fire      = in_valid_ff && ((req_ff.command == CMD_SET) || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_load  = fire && (req_ff.command == CMD_GET);

   always_comb begin
      cap_in       = csr_write_enable ? csr_write_data : cap_ff;
      in_valid_in  = req_xfer ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      req_in       = req_ff;
      if (req_xfer) begin
         req_in.command = cmd_type'(req_command);
         req_in.key     = req_key;
         req_in.value   = req_value;
      end
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_in       = rsp_load ? lookup : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   kvc_store u_store (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .req     (req_ff),
      .cap_eff (cap_eff),
      .lookup  (lookup),
      .status  (status)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_ff.hit;
   assign rsp_value_res = rsp_ff.value;

   // occupancy count tracks the valid bits
   assert property (@(posedge clock) disable iff (reset)
      $countones(status.valid) == int'(status.count))
      else $error("occupancy count out of step with valid bits");

   // only a get facing a full output register stalls the input
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && (req_ff.command == CMD_GET) && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without a pending get");

   // a miss always returns all ones
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_value_res == MISS_VALUE))
      else $error("miss result carries a value");

endmodule

`default_nettype wire
